>>> design/mccd_pkg.sv
// Package for the MIDI CC duplicator with gain: constants, types and the controller states.
// Depends on nothing; every other design file except mccd_stream_if imports it.
`default_nettype none
package mccd_pkg;
    localparam int NUM_MAPS = 8;
    localparam int MAP_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [2:0] CFG_CHANNEL_SELECT = 3'd0;
    localparam logic [2:0] CFG_BOOST_ENABLE = 3'd1;
    localparam logic [2:0] CFG_DEST_ONE_OFFSET = 3'd2;
    localparam logic [2:0] CFG_DEST_ONE_GAIN_OFFSET = 3'd3;
    localparam logic [2:0] CFG_DEST_TWO_OFFSET = 3'd4;
    localparam logic [2:0] CFG_DEST_TWO_GAIN_OFFSET = 3'd5;
    localparam logic [2:0] CFG_SOURCE_CC_TABLE = 3'd6;

    localparam logic [3:0] CC_NIBBLE = 4'hB;
    localparam logic [6:0] VALUE_MAX = 7'h7F;
    localparam logic [7:0] GAIN_RAW_RESET = 8'd127;
    // Reciprocals for the scaler: ceil(2^23 / 127) and ceil(2^22 / 63). Both are exact
    // for every product of two bytes.
    localparam logic [16:0] RECIP_NORMAL = 17'd66053;
    localparam logic [16:0] RECIP_BOOST = 17'd66577;

    // Controller steps. Per slot: gain one, gain two, source, dest one, dest two.
    typedef enum logic [3:0] {
        S_IDLE, S_CLASSIFY, S_GAIN0, S_GAIN1, S_SOURCE, S_DEST0, S_DEST1,
        S_DIVIDE, S_EMIT, S_WAIT, S_NEXT, S_FINISH, S_FLUSH
    } t_state;

    // What the datapath should send next.
    typedef enum logic [1:0] {
        K_PASS, K_SOURCE, K_SCALED
    } t_kind;

    typedef struct packed {
        logic        load;       // capture the input transaction
        logic        clr_slot;   // slot counter back to zero
        logic        inc_slot;
        logic        gain_wr;    // write gain entry of lane
        logic        src_wr;     // store source value of current slot
        logic        div_start;  // start scaling
        logic        push;       // write a result to the staging register
        logic        flush;      // release the staged result as the last one
        logic        lane;       // destination index
        logic        use_new;    // scale the input value, not the stored one
        logic        set_handled;
        t_kind       kind;
    } t_cmd;

    typedef struct packed {
        logic is_cc;
        logic len_ok;
        logic chan_other;
        logic slot_en;
        logic gain_hit0;
        logic gain_hit1;
        logic src_hit;
        logic src_valid;
        logic dest_en0;
        logic dest_en1;
        logic last_slot;
        logic handled;
        logic div_done;
        logic out_free;
    } t_status;
endpackage
`default_nettype wire

>>> design/mccd_stream_if.sv
// Valid/ready stream interface used for both the input and the result channel.
// Depends on nothing.
`default_nettype none
interface mccd_stream_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_stamp;
    logic [7:0]  status;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  length;
    logic        last_of_run;
    modport source (output valid, time_stamp, status, first_data, second_data, length,
                    last_of_run, input ready);
    modport sink (input valid, time_stamp, status, first_data, second_data, length,
                  last_of_run, output ready);
endinterface
`default_nettype wire

>>> design/midi_cc_duplicator_with_gain_unit.sv
// Top level of the MIDI CC duplicator with gain.
// Depends on mccd_pkg, mccd_stream_if, mccd_ctrl and mccd_datapath.
//
//  Channel   Direction  Handshake          Payload
//  in_s      sink       valid/ready        time_stamp, status, first/second data, length
//  out_s     source     valid/ready        same fields plus last_of_run
//  cfg       write      i_cfg_we           i_cfg_index, i_cfg_data (64 bits)
//
// A transaction is accepted in S_IDLE, classified in S_CLASSIFY. A dropped message
// returns to S_IDLE; pass-through uses S_EMIT, S_FINISH and S_FLUSH. A scanned CC takes
// S_GAIN0 and S_NEXT per disabled slot, plus S_GAIN1 and S_SOURCE if enabled, S_DEST0
// and S_DEST1 on a source match, S_DIVIDE and S_WAIT per scaled result (product,
// reciprocal multiply, send), then S_FINISH, S_FLUSH. Results are staged one deep so
// the last one of a run can be marked. Synchronous active-low reset restores control
// and config registers, invalidates every source value and sets all gains to unity. A
// stalled output holds the sequencer while stage and output register are both full.
`default_nettype none
module midi_cc_duplicator_with_gain_unit
    import mccd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mccd_stream_if.sink                in_s,
    mccd_stream_if.source              out_s
);
    t_cmd    cmd;
    t_status stat;
    logic    in_ready;

    mccd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_s.valid),
        .o_in_ready(in_ready), .i_stat(stat), .o_cmd(cmd)
    );

    mccd_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .in_s(in_s), .out_s(out_s), .i_cmd(cmd), .o_stat(stat)
    );

    a_ready_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready && in_s.valid |-> cmd.load) else $error("accepted without load");
endmodule
`default_nettype wire

>>> design/mccd_ctrl.sv
// Controller state machine: scans the map slots and sequences result transactions.
// Depends on mccd_pkg.
`default_nettype none
module mccd_ctrl
    import mccd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_stat,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;
    t_state r_ret, n_ret;     // where to go after a result is sent
    logic   r_lane, n_lane;
    logic   r_new, n_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_lane <= 1'b0;
            r_new <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_lane <= n_lane;
            r_new <= n_new;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        n_lane = r_lane;
        n_new = r_new;
        o_cmd = '0;
        o_cmd.kind = K_PASS;
        o_cmd.lane = r_lane;
        o_cmd.use_new = r_new;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                o_cmd.clr_slot = 1'b1;
                if (!i_stat.is_cc) begin
                    n_ret = S_FINISH;
                    n_state = S_EMIT;
                end else if (!i_stat.len_ok) begin
                    n_state = S_IDLE;
                end else if (i_stat.chan_other) begin
                    n_ret = S_FINISH;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_GAIN0;
                end
            end
            S_GAIN0: begin
                n_state = S_GAIN1;
                if (!i_stat.slot_en) begin
                    n_state = S_NEXT;
                end else if (i_stat.gain_hit0) begin
                    o_cmd.gain_wr = 1'b1;
                    o_cmd.lane = 1'b0;
                    o_cmd.set_handled = 1'b1;
                    if (i_stat.src_valid && i_stat.dest_en0) begin
                        n_lane = 1'b0;
                        n_new = 1'b0;
                        n_ret = S_GAIN1;
                        n_state = S_DIVIDE;
                    end
                end
            end
            S_GAIN1: begin
                n_state = S_SOURCE;
                if (i_stat.gain_hit1) begin
                    o_cmd.gain_wr = 1'b1;
                    o_cmd.lane = 1'b1;
                    o_cmd.set_handled = 1'b1;
                    if (i_stat.src_valid && i_stat.dest_en1) begin
                        n_lane = 1'b1;
                        n_new = 1'b0;
                        n_ret = S_SOURCE;
                        n_state = S_DIVIDE;
                    end
                end
            end
            S_SOURCE: begin
                if (i_stat.src_hit) begin
                    if (i_stat.out_free) begin
                        o_cmd.kind = K_SOURCE;
                        o_cmd.push = 1'b1;
                        o_cmd.src_wr = 1'b1;
                        o_cmd.set_handled = 1'b1;
                        n_state = S_DEST0;
                    end
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_DEST0: begin
                n_state = S_DEST1;
                if (i_stat.dest_en0) begin
                    n_lane = 1'b0;
                    n_new = 1'b1;
                    n_ret = S_DEST1;
                    n_state = S_DIVIDE;
                end
            end
            S_DEST1: begin
                n_state = S_NEXT;
                if (i_stat.dest_en1) begin
                    n_lane = 1'b1;
                    n_new = 1'b1;
                    n_ret = S_NEXT;
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.div_done && i_stat.out_free) begin
                    o_cmd.kind = K_SCALED;
                    o_cmd.push = 1'b1;
                    n_state = r_ret;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.kind = K_PASS;
                    o_cmd.push = 1'b1;
                    n_state = r_ret;
                end
            end
            S_NEXT: begin
                o_cmd.inc_slot = 1'b1;
                n_state = i_stat.last_slot ? S_FINISH : S_GAIN0;
            end
            S_FINISH: begin
                // Unhandled CC passes through; otherwise the run is complete.
                if (i_stat.is_cc && !i_stat.chan_other && !i_stat.handled) begin
                    n_ret = S_FLUSH;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // The staged result, if any, leaves marked as the last of the run.
                if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_in_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_stat.out_free) else $error("push onto a full output");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == S_WAIT) else $error("divide not followed by wait");
endmodule
`default_nettype wire

>>> design/mccd_datapath.sv
// Datapath: configuration registers, per-slot state, the scaler and the output registers.
// Depends on mccd_pkg and mccd_stream_if.
`default_nettype none
module mccd_datapath
    import mccd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mccd_stream_if.sink                in_s,
    mccd_stream_if.source              out_s,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_stat
);
    logic [4:0]  r_chan_sel;
    logic        r_boost_en;
    logic [7:0]  r_doff [2];
    logic [7:0]  r_goff [2];
    logic [63:0] r_src_table;

    logic [31:0] r_time;
    logic [7:0]  r_st, r_d1, r_d2;
    logic [1:0]  r_len;
    logic [MAP_W-1:0] r_slot;
    logic        r_last_slot;
    logic        r_handled;

    logic [NUM_MAPS-1:0] r_src_valid;
    logic [7:0]  r_src_val [NUM_MAPS];
    logic [7:0]  r_gain_raw [2*NUM_MAPS];
    logic [2*NUM_MAPS-1:0] r_gain_boost;

    // Scaler: the product is latched, then divided by 63 or 127 with a reciprocal
    // multiply on the following cycle.
    logic [15:0] r_prod;
    logic        r_prod_boost;
    logic [10:0] r_quo;
    logic        r_busy;
    logic [6:0]  r_dest_cc;

    // One staged result: it is sent on once the next result or the end of the run
    // is known, so its last flag is exact.
    logic        r_stg_valid;
    logic [7:0]  r_s_st, r_s_d1, r_s_d2;
    logic [1:0]  r_s_len;

    logic        r_out_valid;
    logic [31:0] r_o_time;
    logic [7:0]  r_o_st, r_o_d1, r_o_d2;
    logic [1:0]  r_o_len;
    logic        r_o_last;

    logic [7:0]  src;
    logic [3:0]  chs;
    logic [4:0]  sel_m1;
    logic [3:0]  gidx;
    logic [7:0]  gsum0, gsum1;
    logic [7:0]  sv;
    logic [15:0] prod;
    logic [32:0] recip_prod;
    logic [10:0] quo_next;
    logic [7:0]  pass_d1, pass_d2;
    logic [7:0]  gen_st;
    logic        move;

    always_comb begin
        src = r_src_table[{r_slot, 3'b000} +: 8];
        sel_m1 = r_chan_sel - 5'd1;
        chs = (sel_m1 > 5'd15) ? 4'hF : sel_m1[3:0];
        gidx = {r_slot, i_cmd.lane};
        gsum0 = src + r_goff[0];
        gsum1 = src + r_goff[1];
        sv = i_cmd.use_new ? r_d2 : r_src_val[r_slot];
        prod = sv * r_gain_raw[gidx];
        recip_prod = r_prod * (r_prod_boost ? RECIP_BOOST : RECIP_NORMAL);
        quo_next = r_prod_boost ? recip_prod[32:22] : {1'b0, recip_prod[32:23]};
        pass_d1 = (r_len >= 2'd2) ? r_d1 : 8'd0;
        pass_d2 = (r_len >= 2'd3) ? r_d2 : 8'd0;
        gen_st = {CC_NIBBLE, r_st[3:0]};
        move = (i_cmd.push || i_cmd.flush) && r_stg_valid;
        o_stat.is_cc = r_st[7:4] == CC_NIBBLE;
        o_stat.len_ok = r_len == 2'd3;
        o_stat.chan_other = (r_chan_sel != 5'd0) && (chs != r_st[3:0]);
        o_stat.slot_en = !src[7];
        o_stat.gain_hit0 = !r_goff[0][7] && (r_d1 == {1'b0, gsum0[6:0]});
        o_stat.gain_hit1 = !src[7] && !r_goff[1][7] && (r_d1 == {1'b0, gsum1[6:0]});
        o_stat.src_hit = !src[7] && (r_d1 == src);
        o_stat.src_valid = r_src_valid[r_slot];
        o_stat.dest_en0 = !r_doff[0][7];
        o_stat.dest_en1 = !r_doff[1][7];
        o_stat.last_slot = r_last_slot;
        o_stat.handled = r_handled;
        o_stat.div_done = !r_busy;
        o_stat.out_free = !r_stg_valid || !r_out_valid || out_s.ready;
    end

    assign in_s.ready = 1'b0 | i_cmd.load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_sel <= 5'd0;
            r_boost_en <= 1'b0;
            r_doff[0] <= 8'd1;
            r_goff[0] <= 8'd100;
            r_doff[1] <= 8'd2;
            r_goff[1] <= 8'd101;
            r_src_table <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_SELECT: r_chan_sel <= i_cfg_data[4:0];
                CFG_BOOST_ENABLE: r_boost_en <= i_cfg_data[0];
                CFG_DEST_ONE_OFFSET: r_doff[0] <= i_cfg_data[7:0];
                CFG_DEST_ONE_GAIN_OFFSET: r_goff[0] <= i_cfg_data[7:0];
                CFG_DEST_TWO_OFFSET: r_doff[1] <= i_cfg_data[7:0];
                CFG_DEST_TWO_GAIN_OFFSET: r_goff[1] <= i_cfg_data[7:0];
                CFG_SOURCE_CC_TABLE: r_src_table <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_time <= in_s.time_stamp;
            r_st <= in_s.status;
            r_d1 <= in_s.first_data;
            r_d2 <= in_s.second_data;
            r_len <= in_s.length;
        end
        if (i_cmd.src_wr) r_src_val[r_slot] <= r_d2;
        if (i_cmd.div_start) begin
            r_prod <= prod;
            r_prod_boost <= r_gain_boost[gidx];
            r_dest_cc <= src[6:0] + r_doff[i_cmd.lane][6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_valid <= '0;
            for (int i = 0; i < 2*NUM_MAPS; i++) begin
                r_gain_raw[i] <= GAIN_RAW_RESET;
            end
            r_gain_boost <= '0;
            r_slot <= '0;
            r_last_slot <= 1'b0;
            r_handled <= 1'b0;
            r_busy <= 1'b0;
            r_quo <= '0;
        end else begin
            if (i_cmd.load) r_handled <= 1'b0;
            else if (i_cmd.set_handled) r_handled <= 1'b1;
            if (i_cmd.clr_slot) begin
                r_slot <= '0;
                r_last_slot <= (NUM_MAPS == 1);
            end else if (i_cmd.inc_slot) begin
                r_slot <= r_slot + 1'b1;
                r_last_slot <= ({1'b0, r_slot} + 2'd2) == (MAP_W+1)'(NUM_MAPS);
            end
            if (i_cmd.src_wr) r_src_valid[r_slot] <= 1'b1;
            if (i_cmd.gain_wr) begin
                r_gain_raw[gidx] <= r_d2;
                r_gain_boost[gidx] <= r_boost_en;
            end
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= quo_next;
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) r_stg_valid <= 1'b1;
            else if (i_cmd.flush) r_stg_valid <= 1'b0;
            if (move) r_out_valid <= 1'b1;
            else if (out_s.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_o_time <= r_time;
            r_o_st <= r_s_st;
            r_o_d1 <= r_s_d1;
            r_o_d2 <= r_s_d2;
            r_o_len <= r_s_len;
            r_o_last <= i_cmd.flush;
        end
        if (i_cmd.push) begin
            unique case (i_cmd.kind)
                K_PASS: begin
                    r_s_st <= r_st;
                    r_s_d1 <= o_stat.is_cc ? r_d1 : pass_d1;
                    r_s_d2 <= o_stat.is_cc ? r_d2 : pass_d2;
                    r_s_len <= r_len;
                end
                K_SOURCE: begin
                    r_s_st <= r_st;
                    r_s_d1 <= r_d1;
                    r_s_d2 <= r_d2;
                    r_s_len <= 2'd3;
                end
                default: begin
                    r_s_st <= gen_st;
                    r_s_d1 <= {1'b0, r_dest_cc};
                    r_s_d2 <= (r_quo > 11'd127) ? {1'b0, VALUE_MAX} : r_quo[7:0];
                    r_s_len <= 2'd3;
                end
            endcase
        end
    end

    assign out_s.valid = r_out_valid;
    assign out_s.time_stamp = r_o_time;
    assign out_s.status = r_o_st;
    assign out_s.first_data = r_o_d1;
    assign out_s.second_data = r_o_d2;
    assign out_s.length = r_o_len;
    assign out_s.last_of_run = r_o_last;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !out_s.ready |=> r_out_valid) else $error("result dropped");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_busy) else $error("scaler did not start");
    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push && i_cmd.kind == K_SCALED |-> !r_busy) else $error("early scaled push");
endmodule
`default_nettype wire
